[src/nmea_rmc_position_parser_core_macros.svh]
// assertion macros for the rmc position parser
`ifndef NMEA_RMC_POSITION_PARSER_CORE_MACROS_SVH
`define NMEA_RMC_POSITION_PARSER_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define NRPP_ASSERT_HOLDS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("nrpp invariant violated");
`define NRPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("nrpp sequence violated");
`else
`define NRPP_ASSERT_HOLDS(label, clk, rst_n, cond)
`define NRPP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/nrpp_pkg.sv]
// shared types, constants and tables of the rmc position parser
package nrpp_pkg;

	localparam int RX_BYTE_W = 8;
	localparam int SCALE_W   = 12;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 12'd1151;

	localparam int MIN_FRAC_DIGITS = 4;
	localparam int FRAC_KEEP = (MIN_FRAC_DIGITS < 4) ? MIN_FRAC_DIGITS : 4;

	localparam logic [6:0]  LAT_DEG_MAX = 7'd90;
	localparam logic [7:0]  LON_DEG_MAX = 8'd180;
	localparam logic [19:0] MIN_MAX     = 20'd599999;
	localparam logic [19:0] SPEED_MAX   = 20'd999999;
	localparam logic [15:0] TRACK_MAX   = 16'd35999;

	localparam logic [3:0] LAT_DEG_DIGITS = 4'd2;
	localparam logic [3:0] LON_DEG_DIGITS = 4'd3;

	localparam logic [2:0] HDR_LEN = 3'd6;

	// field numbers counted by commas after the header
	localparam logic [3:0] FLD_STATUS = 4'd2;
	localparam logic [3:0] FLD_LAT    = 4'd3;
	localparam logic [3:0] FLD_LON    = 4'd5;
	localparam logic [3:0] FLD_SPEED  = 4'd7;
	localparam logic [3:0] FLD_TRACK  = 4'd8;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_A      = 8'h41;

	// floor(y / 3) as (y * DIV3_RECIP) >> DIV3_SHIFT, exact for y below 2^23
	localparam int DIV3_SHIFT = 23;
	localparam logic [21:0] DIV3_RECIP = 22'(((64'd1 << DIV3_SHIFT) / 64'd3) + 64'd1);

	// floor(q / 625) as (q * SPD_RECIP) >> SPD_SHIFT, exact for q below 2^28
	localparam int SPD_SHIFT = 38;
	localparam logic [28:0] SPD_RECIP = 29'(((64'd1 << SPD_SHIFT) / 64'd625) + 64'd1);

	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0: ch = CH_DOLLAR;
			3'd1: ch = 8'h47;
			3'd2: ch = 8'h50;
			3'd3: ch = 8'h52;
			3'd4: ch = 8'h4D;
			3'd5: ch = 8'h43;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	typedef struct packed {
		logic [6:0]  lat_deg;
		logic [19:0] lat_min;
		logic [7:0]  lon_deg;
		logic [19:0] lon_min;
		logic [19:0] speed_milli;
		logic [15:0] track;
		logic        status;
	} raw_fix_t;

	typedef struct packed {
		logic [6:0]  lat_deg;
		logic [19:0] lat_min;
		logic [7:0]  lon_deg;
		logic [19:0] lon_min;
		logic [26:0] lat_degm;
		logic [27:0] lon_degm;
		logic [21:0] lat_y;
		logic [21:0] lon_y;
		logic [31:0] spd_p;
		logic [15:0] track;
		logic        status;
	} fix_prod_t;

	typedef struct packed {
		logic [6:0]  lat_deg;
		logic [19:0] lat_min;
		logic [7:0]  lon_deg;
		logic [19:0] lon_min;
		logic [26:0] lat_degm;
		logic [27:0] lon_degm;
		logic [19:0] lat_q;
		logic [19:0] lon_q;
		logic [18:0] spd_q;
		logic [15:0] track;
		logic        status;
	} fix_quot_t;

	typedef struct packed {
		logic [6:0]  lat_deg;
		logic [19:0] lat_min_e4;
		logic [7:0]  lon_deg;
		logic [19:0] lon_min_e4;
		logic [26:0] latitude_e6;
		logic [27:0] longitude_e6;
		logic [19:0] speed_scaled_e2;
		logic [15:0] track_e2;
		logic        status_active;
	} fix_out_t;

endpackage

[src/nrpp_ifs.sv]
// valid/ready stream interfaces for received bytes and position fixes
interface nrpp_byte_if;
	import nrpp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [RX_BYTE_W-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface nrpp_fix_if;
	import nrpp_pkg::*;
	logic        valid;
	logic        ready;
	logic [6:0]  lat_deg;
	logic [19:0] lat_min_e4;
	logic [7:0]  lon_deg;
	logic [19:0] lon_min_e4;
	logic [26:0] latitude_e6;
	logic [27:0] longitude_e6;
	logic [19:0] speed_scaled_e2;
	logic [15:0] track_e2;
	logic        status_active;
	modport source (output valid, output lat_deg, output lat_min_e4, output lon_deg,
		output lon_min_e4, output latitude_e6, output longitude_e6,
		output speed_scaled_e2, output track_e2, output status_active, input ready);
	modport sink (input valid, input lat_deg, input lat_min_e4, input lon_deg,
		input lon_min_e4, input latitude_e6, input longitude_e6,
		input speed_scaled_e2, input track_e2, input status_active, output ready);
endinterface

[src/nmea_rmc_position_parser_core.sv]
// rmc sentence parser: byte-wise field parse, then a four-stage result pipeline
// throughput: one byte per cycle unless fix stalls; each byte is one parse step
// a terminator passes the snapshot, products, reciprocal quotients and output
// registers in that order before fix.valid rises
// reset: parse state cleared, pipeline empty, speed scale back to 1151
`include "nmea_rmc_position_parser_core_macros.svh"
module nmea_rmc_position_parser_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [nrpp_pkg::SCALE_W-1:0]  cfg_wdata,
	nrpp_byte_if.sink                     rx,
	nrpp_fix_if.source                    fix
);
	import nrpp_pkg::*;

	logic [SCALE_W-1:0] speed_scale_q;

	logic [2:0]  header_pos_q, header_pos_d;
	logic        in_sentence_q, in_sentence_d;
	logic [3:0]  field_index_q, field_index_d;
	logic [3:0]  char_pos_q, char_pos_d;
	logic        after_point_q, after_point_d;
	logic [2:0]  frac_count_q, frac_count_d;
	logic [6:0]  lat_deg_acc_q, lat_deg_acc_d;
	logic [19:0] lat_min_acc_q, lat_min_acc_d;
	logic [7:0]  lon_deg_acc_q, lon_deg_acc_d;
	logic [19:0] lon_min_acc_q, lon_min_acc_d;
	logic [19:0] speed_milli_acc_q, speed_milli_acc_d;
	logic [15:0] track_acc_q, track_acc_d;
	logic        status_flag_q, status_flag_d;

	logic [7:0]  c;
	logic [3:0]  d;
	logic        rx_fire;
	logic        is_digit;
	logic        is_term;
	logic        emit;
	logic        acc_in_range;

	logic [9:0]  lat_deg_push;
	logic [10:0] lon_deg_push;
	logic [6:0]  lat_deg_sat;
	logic [7:0]  lon_deg_sat;
	logic [19:0] cmin;
	logic [19:0] mfrac;
	logic [22:0] cmin_int;
	logic [20:0] cmin_frac;
	logic [19:0] cmin_int_sat;
	logic [19:0] cmin_frac_sat;
	logic [19:0] sfrac;
	logic [23:0] spd_int;
	logic [20:0] spd_frac;
	logic [19:0] spd_int_sat;
	logic [19:0] spd_frac_sat;
	logic [18:0] trk_int;
	logic [16:0] trk_frac;
	logic [15:0] trk_int_sat;
	logic [15:0] trk_frac_sat;

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        adv1, adv2, adv3, adv4;
	raw_fix_t    raw_s1;
	fix_prod_t   prod_s2;
	fix_quot_t   quot_s3;
	fix_out_t    out_s4;
	logic [43:0] lat_div;
	logic [43:0] lon_div;
	logic [56:0] spd_div;

	// byte decode
	assign c        = rx.rx_byte;
	assign d        = c[3:0];
	assign rx_fire  = rx.valid && rx.ready;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
	assign is_term  = (c == CH_STAR) || (c == CH_CR) || (c == CH_LF) || (c == CH_DOLLAR);

	// digit accumulation candidates
	assign lat_deg_push = 10'(lat_deg_acc_q) * 10'd10 + 10'(d);
	assign lon_deg_push = 11'(lon_deg_acc_q) * 11'd10 + 11'(d);
	assign lat_deg_sat  = (lat_deg_push > 10'(LAT_DEG_MAX)) ? LAT_DEG_MAX : lat_deg_push[6:0];
	assign lon_deg_sat  = (lon_deg_push > 11'(LON_DEG_MAX)) ? LON_DEG_MAX : lon_deg_push[7:0];

	assign cmin = (field_index_q == FLD_LON) ? lon_min_acc_q : lat_min_acc_q;

	always_comb begin
		unique case (frac_count_q[1:0])
			2'd0: mfrac = 20'(d) * 20'd1000;
			2'd1: mfrac = 20'(d) * 20'd100;
			2'd2: mfrac = 20'(d) * 20'd10;
			default: mfrac = 20'(d);
		endcase
	end

	always_comb begin
		unique case (frac_count_q[1:0])
			2'd0: sfrac = 20'(d) * 20'd100;
			2'd1: sfrac = 20'(d) * 20'd10;
			default: sfrac = 20'(d);
		endcase
	end

	assign cmin_int      = 23'(cmin) * 23'd10 + 23'(d) * 23'd10000;
	assign cmin_frac     = 21'(cmin) + 21'(mfrac);
	assign cmin_int_sat  = (cmin_int > 23'(MIN_MAX)) ? MIN_MAX : cmin_int[19:0];
	assign cmin_frac_sat = (cmin_frac > 21'(MIN_MAX)) ? MIN_MAX : cmin_frac[19:0];

	assign spd_int      = 24'(speed_milli_acc_q) * 24'd10 + 24'(d) * 24'd1000;
	assign spd_frac     = 21'(speed_milli_acc_q) + 21'(sfrac);
	assign spd_int_sat  = (spd_int > 24'(SPEED_MAX)) ? SPEED_MAX : spd_int[19:0];
	assign spd_frac_sat = (spd_frac > 21'(SPEED_MAX)) ? SPEED_MAX : spd_frac[19:0];

	assign trk_int      = 19'(track_acc_q) * 19'd10 + 19'(d) * 19'd100;
	assign trk_frac     = 17'(track_acc_q) + ((frac_count_q == 3'd0) ? 17'(d) * 17'd10 : 17'(d));
	assign trk_int_sat  = (trk_int > 19'(TRACK_MAX)) ? TRACK_MAX : trk_int[15:0];
	assign trk_frac_sat = (trk_frac > 17'(TRACK_MAX)) ? TRACK_MAX : trk_frac[15:0];

	// parse state update for one accepted byte
	always_comb begin
		header_pos_d      = header_pos_q;
		in_sentence_d     = in_sentence_q;
		field_index_d     = field_index_q;
		char_pos_d        = char_pos_q;
		after_point_d     = after_point_q;
		frac_count_d      = frac_count_q;
		lat_deg_acc_d     = lat_deg_acc_q;
		lat_min_acc_d     = lat_min_acc_q;
		lon_deg_acc_d     = lon_deg_acc_q;
		lon_min_acc_d     = lon_min_acc_q;
		speed_milli_acc_d = speed_milli_acc_q;
		track_acc_d       = track_acc_q;
		status_flag_d     = status_flag_q;
		emit              = 1'b0;
		if (rx_fire) begin
			if (in_sentence_q) begin
				if (is_term) begin
					emit          = 1'b1;
					in_sentence_d = 1'b0;
					header_pos_d  = (c == CH_DOLLAR) ? 3'd1 : 3'd0;
				end else if (c == CH_COMMA) begin
					if (field_index_q != 4'hF) begin
						field_index_d = field_index_q + 4'd1;
					end
					char_pos_d    = '0;
					after_point_d = 1'b0;
					frac_count_d  = '0;
				end else if (field_index_q == FLD_STATUS) begin
					status_flag_d = (char_pos_q == 4'd0) && !after_point_q
						&& (frac_count_q == 3'd0) && (c == CH_A);
					if (char_pos_q != 4'hF) begin
						char_pos_d = char_pos_q + 4'd1;
					end
				end else if (c == CH_POINT) begin
					after_point_d = 1'b1;
				end else if (is_digit) begin
					priority if (field_index_q == FLD_LAT) begin
						if (after_point_q) begin
							if (frac_count_q < 3'(FRAC_KEEP)) begin
								lat_min_acc_d = cmin_frac_sat;
							end
						end else if (char_pos_q < LAT_DEG_DIGITS) begin
							lat_deg_acc_d = lat_deg_sat;
						end else begin
							lat_min_acc_d = cmin_int_sat;
						end
					end else if (field_index_q == FLD_LON) begin
						if (after_point_q) begin
							if (frac_count_q < 3'(FRAC_KEEP)) begin
								lon_min_acc_d = cmin_frac_sat;
							end
						end else if (char_pos_q < LON_DEG_DIGITS) begin
							lon_deg_acc_d = lon_deg_sat;
						end else begin
							lon_min_acc_d = cmin_int_sat;
						end
					end else if (field_index_q == FLD_SPEED) begin
						if (!after_point_q) begin
							speed_milli_acc_d = spd_int_sat;
						end else if (frac_count_q < 3'd3) begin
							speed_milli_acc_d = spd_frac_sat;
						end
					end else if (field_index_q == FLD_TRACK) begin
						if (!after_point_q) begin
							track_acc_d = trk_int_sat;
						end else if (frac_count_q < 3'd2) begin
							track_acc_d = trk_frac_sat;
						end
					end else begin
						// other fields only count digits
					end
					if (after_point_q) begin
						if (frac_count_q != 3'd7) begin
							frac_count_d = frac_count_q + 3'd1;
						end
					end else if (char_pos_q != 4'hF) begin
						char_pos_d = char_pos_q + 4'd1;
					end
				end
			end else begin
				if (c == CH_DOLLAR) begin
					header_pos_d = 3'd1;
				end else if ((header_pos_q != 3'd0) && (header_pos_q < HDR_LEN)
						&& (c == hdr_char(header_pos_q))) begin
					if (header_pos_q + 3'd1 == HDR_LEN) begin
						header_pos_d      = 3'd0;
						in_sentence_d     = 1'b1;
						field_index_d     = '0;
						char_pos_d        = '0;
						after_point_d     = 1'b0;
						frac_count_d      = '0;
						lat_deg_acc_d     = '0;
						lat_min_acc_d     = '0;
						lon_deg_acc_d     = '0;
						lon_min_acc_d     = '0;
						speed_milli_acc_d = '0;
						track_acc_d       = '0;
						status_flag_d     = 1'b0;
					end else begin
						header_pos_d = header_pos_q + 3'd1;
					end
				end else begin
					header_pos_d = 3'd0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_scale_q     <= SCALE_RESET;
			header_pos_q      <= '0;
			in_sentence_q     <= 1'b0;
			field_index_q     <= '0;
			char_pos_q        <= '0;
			after_point_q     <= 1'b0;
			frac_count_q      <= '0;
			lat_deg_acc_q     <= '0;
			lat_min_acc_q     <= '0;
			lon_deg_acc_q     <= '0;
			lon_min_acc_q     <= '0;
			speed_milli_acc_q <= '0;
			track_acc_q       <= '0;
			status_flag_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				speed_scale_q <= cfg_wdata;
			end
			header_pos_q      <= header_pos_d;
			in_sentence_q     <= in_sentence_d;
			field_index_q     <= field_index_d;
			char_pos_q        <= char_pos_d;
			after_point_q     <= after_point_d;
			frac_count_q      <= frac_count_d;
			lat_deg_acc_q     <= lat_deg_acc_d;
			lat_min_acc_q     <= lat_min_acc_d;
			lon_deg_acc_q     <= lon_deg_acc_d;
			lon_min_acc_q     <= lon_min_acc_d;
			speed_milli_acc_q <= speed_milli_acc_d;
			track_acc_q       <= track_acc_d;
			status_flag_q     <= status_flag_d;
		end
	end

	// result pipeline flow control, each stage fills its own bubble
	assign adv4     = !v_s4 || fix.ready;
	assign adv3     = !v_s3 || adv4;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign rx.ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= emit;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
			if (adv4) begin
				v_s4 <= v_s3;
			end
		end
	end

	assign lat_div = 44'(prod_s2.lat_y) * 44'(DIV3_RECIP);
	assign lon_div = 44'(prod_s2.lon_y) * 44'(DIV3_RECIP);
	assign spd_div = 57'(prod_s2.spd_p[31:4]) * 57'(SPD_RECIP);

	always_ff @(posedge clk) begin
		// snapshot of the finished sentence
		if (adv1 && emit) begin
			raw_s1.lat_deg     <= lat_deg_acc_q;
			raw_s1.lat_min     <= lat_min_acc_q;
			raw_s1.lon_deg     <= lon_deg_acc_q;
			raw_s1.lon_min     <= lon_min_acc_q;
			raw_s1.speed_milli <= speed_milli_acc_q;
			raw_s1.track       <= track_acc_q;
			raw_s1.status      <= status_flag_q;
		end
		// degree weights, minutes times five, raw speed product
		if (adv2 && v_s1) begin
			prod_s2.lat_deg  <= raw_s1.lat_deg;
			prod_s2.lat_min  <= raw_s1.lat_min;
			prod_s2.lon_deg  <= raw_s1.lon_deg;
			prod_s2.lon_min  <= raw_s1.lon_min;
			prod_s2.lat_degm <= 27'(raw_s1.lat_deg) * 27'd1000000;
			prod_s2.lon_degm <= 28'(raw_s1.lon_deg) * 28'd1000000;
			prod_s2.lat_y    <= 22'(raw_s1.lat_min) * 22'd5;
			prod_s2.lon_y    <= 22'(raw_s1.lon_min) * 22'd5;
			prod_s2.spd_p    <= 32'(raw_s1.speed_milli) * 32'(speed_scale_q);
			prod_s2.track    <= raw_s1.track;
			prod_s2.status   <= raw_s1.status;
		end
		// divide by three and by ten thousand through reciprocals
		if (adv3 && v_s2) begin
			quot_s3.lat_deg  <= prod_s2.lat_deg;
			quot_s3.lat_min  <= prod_s2.lat_min;
			quot_s3.lon_deg  <= prod_s2.lon_deg;
			quot_s3.lon_min  <= prod_s2.lon_min;
			quot_s3.lat_degm <= prod_s2.lat_degm;
			quot_s3.lon_degm <= prod_s2.lon_degm;
			quot_s3.lat_q    <= lat_div[DIV3_SHIFT+19:DIV3_SHIFT];
			quot_s3.lon_q    <= lon_div[DIV3_SHIFT+19:DIV3_SHIFT];
			quot_s3.spd_q    <= spd_div[SPD_SHIFT+18:SPD_SHIFT];
			quot_s3.track    <= prod_s2.track;
			quot_s3.status   <= prod_s2.status;
		end
		if (adv4 && v_s3) begin
			out_s4.lat_deg         <= quot_s3.lat_deg;
			out_s4.lat_min_e4      <= quot_s3.lat_min;
			out_s4.lon_deg         <= quot_s3.lon_deg;
			out_s4.lon_min_e4      <= quot_s3.lon_min;
			out_s4.latitude_e6     <= quot_s3.lat_degm + 27'(quot_s3.lat_q);
			out_s4.longitude_e6    <= quot_s3.lon_degm + 28'(quot_s3.lon_q);
			out_s4.speed_scaled_e2 <= (20'(quot_s3.spd_q) > SPEED_MAX) ? SPEED_MAX
				: 20'(quot_s3.spd_q);
			out_s4.track_e2        <= quot_s3.track;
			out_s4.status_active   <= quot_s3.status;
		end
	end

	assign fix.valid           = v_s4;
	assign fix.lat_deg         = out_s4.lat_deg;
	assign fix.lat_min_e4      = out_s4.lat_min_e4;
	assign fix.lon_deg         = out_s4.lon_deg;
	assign fix.lon_min_e4      = out_s4.lon_min_e4;
	assign fix.latitude_e6     = out_s4.latitude_e6;
	assign fix.longitude_e6    = out_s4.longitude_e6;
	assign fix.speed_scaled_e2 = out_s4.speed_scaled_e2;
	assign fix.track_e2        = out_s4.track_e2;
	assign fix.status_active   = out_s4.status_active;

	assign acc_in_range = (lat_deg_acc_q <= LAT_DEG_MAX) && (lon_deg_acc_q <= LON_DEG_MAX)
		&& (lat_min_acc_q <= MIN_MAX) && (lon_min_acc_q <= MIN_MAX);

	`NRPP_ASSERT_NEXT(a_emit_fills_snapshot, clk, arst_n, emit, v_s1)
	`NRPP_ASSERT_HOLDS(a_no_hunt_in_sentence, clk, arst_n, !in_sentence_q || (header_pos_q == 3'd0))
	`NRPP_ASSERT_HOLDS(a_frac_after_point, clk, arst_n, (frac_count_q == 3'd0) || after_point_q)
	`NRPP_ASSERT_HOLDS(a_acc_saturated, clk, arst_n, acc_in_range)

endmodule
